### design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent property checked at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that holds at every clock edge, reset included.
`define CHK_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### design/lews_pkg.sv
// Shared types and constants of the lattice walk step unit.
package lews_pkg;
  localparam logic [1:0] KIND_REJ   = 2'd0;
  localparam logic [1:0] KIND_PLACE = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;

  localparam logic [1:0] CFG_LATTICE  = 2'd0;
  localparam logic [1:0] CFG_PARTICLE = 2'd1;
  localparam logic [1:0] CFG_WARMUP   = 2'd2;

  localparam int IDX_W = 16;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] idx;
    logic [1:0]       dir;
    logic [5:0]       px;
    logic [5:0]       py;
    logic [6:0]       size;
  } cmd_t;
endpackage

### design/lews_queue.sv
// Two-entry command queue between the front and the back.
module lews_queue import lews_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic not_empty,
  output logic full
);
  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head      = entry[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end
endmodule

### design/lews_front.sv
// Front end: configuration registers and request classification.
module lews_front import lews_pkg::*; #(
  parameter int LATTICE_MAX   = 64,
  parameter int PARTICLES_MAX = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        req_type,
  input  logic [9:0]  particle,
  input  logic [1:0]  direction,
  input  logic [5:0]  place_x,
  input  logic [5:0]  place_y,
  output cmd_t        cmd,
  output logic [31:0] warmup
);
  logic [6:0] lattice_size;
  logic [9:0] particle_count;
  logic [31:0] lsz;
  logic [31:0] pidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_size   <= 7'd64;
      particle_count <= 10'd1;
      warmup         <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_LATTICE:  lattice_size   <= cfg_data[6:0];
        CFG_PARTICLE: particle_count <= cfg_data[9:0];
        CFG_WARMUP:   warmup         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lsz = {25'd0, lattice_size};
    if (lsz > 32'd64) lsz = 32'd64;
    if (lsz > 32'(LATTICE_MAX)) lsz = 32'(LATTICE_MAX);
    if (lsz == 32'd0) lsz = 32'd1;
    pidx = {22'd0, particle};
    cmd.idx  = IDX_W'(pidx);
    cmd.dir  = direction;
    cmd.px   = place_x;
    cmd.py   = place_y;
    cmd.size = lsz[6:0];
    if (particle >= particle_count || pidx >= 32'(PARTICLES_MAX)) cmd.kind = KIND_REJ;
    else if (req_type) cmd.kind = KIND_MOVE;
    else cmd.kind = KIND_PLACE;
  end
endmodule

### design/lews_back.sv
// Back end: occupancy and particle stores, move execution and result registers.
module lews_back import lews_pkg::*; #(
  parameter int LATTICE_MAX   = 64,
  parameter int PARTICLES_MAX = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               head,
  input  logic               head_valid,
  input  logic [31:0]        warmup,
  output logic               pop,
  output logic               clearing,
  output logic               done,
  output logic               accepted,
  output logic [5:0]         pos_x,
  output logic [5:0]         pos_y,
  output logic signed [31:0] unwrapped_x,
  output logic signed [31:0] unwrapped_y,
  output logic [31:0]        accepted_count,
  output logic [31:0]        counted_moves
);
  localparam int SITES  = LATTICE_MAX * LATTICE_MAX;
  localparam int SITE_W = $clog2(SITES);
  localparam int REC_W  = $clog2(PARTICLES_MAX);
  localparam int CLR_N  = (SITES > PARTICLES_MAX) ? SITES : PARTICLES_MAX;
  localparam int CLR_W  = $clog2(CLR_N);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_REC  = 2'd1;
  localparam logic [1:0] ST_SITE = 2'd2;
  localparam logic [1:0] ST_SET  = 2'd3;

  typedef struct packed {
    logic [5:0]         x;
    logic [5:0]         y;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
  } rec_t;

  function automatic logic [SITE_W-1:0] site_addr(input logic [5:0] x, input logic [5:0] y);
    logic [31:0] a;
    a = {26'd0, x} * 32'(LATTICE_MAX) + {26'd0, y};
    return a[SITE_W-1:0];
  endfunction

  logic site_mem [SITES];
  rec_t rec_mem  [PARTICLES_MAX];

  logic [1:0]       state;
  cmd_t             cur;
  rec_t             rec_q;
  logic             site_q;
  logic [5:0]       old_x, old_y, new_x, new_y;
  logic [CLR_W-1:0] clr_cnt;
  logic [31:0]      move_attempts, accept_total, count_total;

  logic              site_we, site_wd, rec_we;
  logic [SITE_W-1:0] site_wa, site_ra;
  logic [REC_W-1:0]  rec_wa, rec_ra;
  rec_t              rec_wd;
  logic [5:0]        nx, ny;
  logic signed [31:0] nux, nuy;
  logic              place_ok, move_ok, counting;

  assign pop      = (state == ST_IDLE) && !clearing && head_valid;
  assign rec_ra   = head.idx[REC_W-1:0];
  assign site_ra  = (state == ST_IDLE) ? site_addr(head.px, head.py) : site_addr(nx, ny);
  assign place_ok = ({1'b0, cur.px} < cur.size) && ({1'b0, cur.py} < cur.size) && !site_q;
  assign move_ok  = !site_q;
  assign counting = move_attempts >= warmup;

  // Wrapped target of a move, computed from the record just read.
  always_comb begin
    nx = rec_q.x;
    ny = rec_q.y;
    nux = rec_q.ux;
    nuy = rec_q.uy;
    case (cur.dir)
      2'd0: begin
        nx = ({1'b0, rec_q.x} + 7'd1 >= cur.size) ? 6'd0 : rec_q.x + 6'd1;
        if (rec_q.ux != 32'sh7fffffff) nux = rec_q.ux + 32'sd1;
      end
      2'd1: begin
        nx = (rec_q.x == 6'd0) ? 6'(cur.size - 7'd1) : rec_q.x - 6'd1;
        if (rec_q.ux != 32'sh80000000) nux = rec_q.ux - 32'sd1;
      end
      2'd2: begin
        ny = ({1'b0, rec_q.y} + 7'd1 >= cur.size) ? 6'd0 : rec_q.y + 6'd1;
        if (rec_q.uy != 32'sh7fffffff) nuy = rec_q.uy + 32'sd1;
      end
      default: begin
        ny = (rec_q.y == 6'd0) ? 6'(cur.size - 7'd1) : rec_q.y - 6'd1;
        if (rec_q.uy != 32'sh80000000) nuy = rec_q.uy - 32'sd1;
      end
    endcase
  end

  always_comb begin
    site_we = 1'b0;
    site_wa = site_addr(cur.px, cur.py);
    site_wd = 1'b1;
    rec_we  = 1'b0;
    rec_wa  = cur.idx[REC_W-1:0];
    rec_wd  = '{x: cur.px, y: cur.py, ux: {26'd0, cur.px}, uy: {26'd0, cur.py}};
    if (clearing) begin
      site_we = (32'(clr_cnt) < 32'(SITES));
      site_wa = SITE_W'(clr_cnt);
      site_wd = 1'b0;
      rec_we  = (32'(clr_cnt) < 32'(PARTICLES_MAX));
      rec_wa  = REC_W'(clr_cnt);
      rec_wd  = '0;
    end else begin
      case (state)
        ST_REC: begin
          site_we = (cur.kind == KIND_PLACE) && place_ok;
          rec_we  = (cur.kind == KIND_PLACE) && place_ok;
        end
        ST_SITE: begin
          site_we = move_ok;
          site_wa = site_addr(old_x, old_y);
          site_wd = 1'b0;
          rec_we  = move_ok;
          rec_wd  = '{x: new_x, y: new_y, ux: nux, uy: nuy};
        end
        ST_SET: begin
          site_we = 1'b1;
          site_wa = site_addr(new_x, new_y);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (site_we) site_mem[site_wa] <= site_wd;
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    site_q <= site_mem[site_ra];
    if (pop) rec_q <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      clearing       <= 1'b1;
      clr_cnt        <= '0;
      done           <= 1'b0;
      accepted       <= 1'b0;
      pos_x          <= 6'd0;
      pos_y          <= 6'd0;
      unwrapped_x    <= 32'sd0;
      unwrapped_y    <= 32'sd0;
      accepted_count <= 32'd0;
      counted_moves  <= 32'd0;
      move_attempts  <= 32'd0;
      accept_total   <= 32'd0;
      count_total    <= 32'd0;
    end else begin
      // A result leaves on a rejection, at the end of a placement or after a move lookup.
      done <= pop && (head.kind == KIND_REJ) ||
              !clearing && (state == ST_REC) && (cur.kind == KIND_PLACE) ||
              !clearing && (state == ST_SITE);
      if (clearing) begin
        if (32'(clr_cnt) == CLR_N - 1) clearing <= 1'b0;
        clr_cnt <= clr_cnt + 1'b1;
      end else begin
        case (state)
          ST_IDLE: begin
            if (pop) begin
              cur <= head;
              if (head.kind == KIND_REJ) begin
                accepted       <= 1'b0;
                pos_x          <= 6'd0;
                pos_y          <= 6'd0;
                unwrapped_x    <= 32'sd0;
                unwrapped_y    <= 32'sd0;
                accepted_count <= accept_total;
                counted_moves  <= count_total;
              end else begin
                state <= ST_REC;
              end
            end
          end
          ST_REC: begin
            if (cur.kind == KIND_PLACE) begin
              accepted       <= place_ok;
              pos_x          <= place_ok ? rec_wd.x : rec_q.x;
              pos_y          <= place_ok ? rec_wd.y : rec_q.y;
              unwrapped_x    <= place_ok ? rec_wd.ux : rec_q.ux;
              unwrapped_y    <= place_ok ? rec_wd.uy : rec_q.uy;
              accepted_count <= accept_total;
              counted_moves  <= count_total;
              state          <= ST_IDLE;
            end else begin
              old_x <= rec_q.x;
              old_y <= rec_q.y;
              new_x <= nx;
              new_y <= ny;
              state <= ST_SITE;
            end
          end
          ST_SITE: begin
            accepted       <= move_ok;
            pos_x          <= move_ok ? new_x : old_x;
            pos_y          <= move_ok ? new_y : old_y;
            unwrapped_x    <= move_ok ? nux : rec_q.ux;
            unwrapped_y    <= move_ok ? nuy : rec_q.uy;
            accepted_count <= (counting && move_ok && accept_total != 32'hffffffff) ?
                              accept_total + 32'd1 : accept_total;
            counted_moves  <= (counting && count_total != 32'hffffffff) ?
                              count_total + 32'd1 : count_total;
            if (counting) begin
              if (count_total != 32'hffffffff) count_total <= count_total + 32'd1;
              if (move_ok && accept_total != 32'hffffffff)
                accept_total <= accept_total + 32'd1;
            end
            if (move_attempts != 32'hffffffff) move_attempts <= move_attempts + 32'd1;
            state <= move_ok ? ST_SET : ST_IDLE;
          end
          ST_SET: state <= ST_IDLE;
          default: state <= ST_IDLE;
        endcase
      end
    end
  end
endmodule

### design/lattice_exclusion_walk_step_unit.sv
// Top level of the lattice walk step unit: front end, command queue and back end.
//
// After reset the unit sweeps its occupancy store and particle store to empty and zero,
// one entry of each per cycle; busy stays high during that sweep. A request is taken
// when start is high and busy is low, and lands in a two-entry queue, so busy rises
// only when that queue is full. The back end then handles one request at a time
// through stores that each have a write port and a registered read port. With the back
// end idle, a rejected index gives its result straight from the queue head, a placement
// after reading its target site, and a move attempt after reading the particle record
// and then the target site. An accepted move keeps the back end in a further state,
// because the vacated site is written in ST_SITE and the new site in ST_SET. Meanwhile
// the queue can take further requests while the back end works. Each result is shown
// for exactly one cycle with done high and the receiver cannot hold it off; the result
// ports keep their last values between transfers. Configuration writes are always
// ready and must only be issued while the unit is idle.
module lattice_exclusion_walk_step_unit import lews_pkg::*; #(
  parameter int LATTICE_MAX   = 64,
  parameter int PARTICLES_MAX = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [9:0]         particle,
  input  logic [1:0]         direction,
  input  logic [5:0]         place_x,
  input  logic [5:0]         place_y,
  output logic               done,
  output logic               accepted,
  output logic [5:0]         pos_x,
  output logic [5:0]         pos_y,
  output logic signed [31:0] unwrapped_x,
  output logic signed [31:0] unwrapped_y,
  output logic [31:0]        accepted_count,
  output logic [31:0]        counted_moves,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  cmd_t        cmd, head;
  logic [31:0] warmup;
  logic        push, pop, head_valid, q_full, clearing;

  // Requests are taken whenever the queue has room and the stores are initialized.
  assign busy      = q_full || clearing;
  assign push      = start && !busy;
  assign cfg_ready = 1'b1;

  lews_front #(.LATTICE_MAX(LATTICE_MAX), .PARTICLES_MAX(PARTICLES_MAX)) u_front (
    .clk, .rst,
    .cfg_wr(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .req_type, .particle, .direction, .place_x, .place_y,
    .cmd, .warmup
  );

  lews_queue u_queue (
    .clk, .rst, .push, .push_cmd(cmd), .pop, .head, .not_empty(head_valid), .full(q_full)
  );

  lews_back #(.LATTICE_MAX(LATTICE_MAX), .PARTICLES_MAX(PARTICLES_MAX)) u_back (
    .clk, .rst, .head, .head_valid, .warmup, .pop, .clearing,
    .done, .accepted, .pos_x, .pos_y, .unwrapped_x, .unwrapped_y,
    .accepted_count, .counted_moves
  );
endmodule

### design/lews_checker.sv
// Port-level checker for the lattice walk step unit, with its bind.
`include "assert_macros.svh"
module lews_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [31:0] accepted_count,
  input logic [31:0] counted_moves
);
  `CHK_ANY(a_busy_after_reset, clk, rst |=> busy, "busy low right after reset")
  `CHK_ANY(a_no_result_after_reset, clk, rst |=> !done, "result right after reset")
  `CHK_ALWAYS(a_acc_le_count, clk, rst, done |-> (accepted_count <= counted_moves), "acc > cnt")
  `CHK_ALWAYS(a_hold_between, clk, rst, (!done && !$past(rst)) |-> $stable(counted_moves), "moved")
endmodule

bind lattice_exclusion_walk_step_unit lews_checker u_lews_checker (.*);
